@@ rtl/hte_pkg.sv @@
package hte_pkg;

  localparam int WIN_DEPTH    = 9;
  localparam int AHEAD_DEPTH  = 8;
  localparam int BEHIND_DEPTH = 9;
  localparam int CNT_W        = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [47:0] OPEN_SCRIPT   = "script";
  localparam logic [63:0] OPEN_NOSCRIPT = "noscript";
  localparam logic [39:0] OPEN_STYLE    = "style";
  localparam logic [31:0] OPEN_CODE     = "code";

  localparam logic [55:0] CLOSE_SCRIPT   = "/script";
  localparam logic [71:0] CLOSE_NOSCRIPT = "/noscript";
  localparam logic [47:0] CLOSE_STYLE    = "/style";
  localparam logic [39:0] CLOSE_CODE     = "/code";
  localparam logic [15:0] CLOSE_HASH     = "/#";

  typedef enum logic [1:0] {
    PH_RUN,
    PH_DRAIN,
    PH_FINISH
  } phase_t;

  typedef struct packed {
    logic in_tag_open;
    logic tag_closed;
    logic space_pending;
    logic deleting;
    logic entity_skip;
    logic stopped;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    in_tag_open: 1'b0, tag_closed: 1'b1, space_pending: 1'b0,
    deleting: 1'b0, entity_skip: 1'b0, stopped: 1'b0
  };

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    flags_t     flags;
  } take_t;

endpackage

@@ rtl/html_text_extract_filter.sv @@
// html text extraction filter
// s_axis carries the page one byte per transfer, tlast on the final byte of
// a page. m_axis carries the visible text: tdata[7:0] the text byte, tdata[8]
// set when the byte is real; tlast marks the final result of a page, which is
// an empty result (tdata[8] low) when the page produced no text.
// each byte is held in an 8-byte lookahead window, so its result is registered
// when the eighth byte that follows it is transferred; inside a page one byte is
// taken every cycle while the output register does not hold the filter.
// the transfer with tlast starts a drain: the window (up to 9 bytes) is worked
// off one byte a cycle, while the output can advance, through the same
// single-byte unit, then the finish phase sends the closing result; during the
// drain and the finish phase s_axis_tready is low. all filter state then
// returns to its reset values for the next page.
// results sit in one output register; while it is full and m_axis_tready is
// low the whole filter holds and s_axis_tready drops.
// rst (synchronous, active high) empties the window, clears the output and
// puts the filter in the state for the start of a page.
module html_text_extract_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] out_valid, rest zero
  output logic        m_axis_tlast    // out_last
);
  import hte_pkg::*;

  phase_t                 phase, phase_next;
  logic [7:0]             win [WIN_DEPTH];
  logic [7:0]             win_next [WIN_DEPTH];
  logic [CNT_W-1:0]       count, count_next;
  logic [7:0]             behind [BEHIND_DEPTH];
  logic [7:0]             behind_next [BEHIND_DEPTH];
  logic [CNT_W-1:0]       behind_count, behind_count_next;
  flags_t                 flags, flags_next;
  logic                   held_valid, held_valid_next;
  logic [7:0]             held_byte, held_byte_next;
  logic                   o_valid, o_valid_next;
  logic [7:0]             o_byte, o_byte_next;
  logic                   o_flag, o_flag_next;
  logic                   o_last, o_last_next;

  logic                   advance;
  logic                   in_xfer;
  logic                   do_take;
  logic [7:0]             take_in;
  logic [63:0]            fwd_vec;
  logic [71:0]            back_vec;
  logic [CNT_W-1:0]       avail;
  take_t                  tk;

  function automatic take_t take_byte(input logic [7:0] b, input logic [63:0] fwd,
                                      input logic [CNT_W-1:0] av, input flags_t f,
                                      input logic [71:0] back,
                                      input logic [CNT_W-1:0] bcnt);
    take_t r;
    logic  is_blank;
    logic  back_hit;
    logic  open_hit;
    r.emit  = 1'b0;
    r.data  = CH_SPACE;
    r.flags = f;
    is_blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    back_hit = (bcnt > 4'd7 && back[55:0] == CLOSE_SCRIPT) ||
               (bcnt > 4'd9 && back[71:0] == CLOSE_NOSCRIPT) ||
               (bcnt > 4'd6 && back[47:0] == CLOSE_STYLE) ||
               (bcnt > 4'd5 && back[39:0] == CLOSE_CODE) ||
               (bcnt > 4'd2 && back[15:0] == CLOSE_HASH);
    open_hit = (av >= 4'd8 && fwd == OPEN_NOSCRIPT) ||
               (fwd[63:24] == OPEN_STYLE) ||
               (fwd[63:32] == OPEN_CODE) ||
               (fwd[63:56] == CH_HASH);
    if (!f.stopped) begin
      if (f.entity_skip) begin
        if (b == CH_SEMI) r.flags.entity_skip = 1'b0;
      end else if (is_blank) begin
        if (!f.space_pending) begin
          r.emit = 1'b1;
          r.flags.space_pending = 1'b1;
        end
      end else if (b == CH_LT) begin
        if (!f.deleting) begin
          r.flags.in_tag_open = 1'b1;
          r.flags.tag_closed  = 1'b0;
          if (av >= 4'd6 && fwd[63:16] == OPEN_SCRIPT) begin
            r.flags.deleting = 1'b1;
          end else if (av < 4'd7) begin
            r.flags.stopped = 1'b1;
          end else begin
            r.flags.deleting = open_hit;
          end
        end
      end else if (b == CH_GT) begin
        if (f.deleting && back_hit) r.flags.deleting = 1'b0;
        if (f.in_tag_open) begin
          r.flags.tag_closed  = 1'b1;
          r.flags.in_tag_open = 1'b0;
        end
      end else if (b == CH_AMP) begin
        if (!f.deleting && f.tag_closed) r.flags.entity_skip = 1'b1;
      end else begin
        if (!f.deleting && f.tag_closed) begin
          r.emit = 1'b1;
          r.data = b;
          r.flags.space_pending = 1'b0;
        end
      end
    end
    return r;
  endfunction

  assign advance       = !o_valid || m_axis_tready;
  assign s_axis_tready = (phase == PH_RUN) && advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {7'd0, o_flag, o_byte};
  assign m_axis_tlast  = o_last;

  // lookahead seen by the head byte: in steady flow the newest byte is the
  // incoming transfer, while draining it is the rest of the window
  always_comb begin
    for (int i = 0; i < AHEAD_DEPTH; i++) begin
      if (phase == PH_RUN && i == AHEAD_DEPTH - 1) begin
        fwd_vec[8*(AHEAD_DEPTH-1-i) +: 8] = s_axis_tdata;
      end else begin
        fwd_vec[8*(AHEAD_DEPTH-1-i) +: 8] = win[i+1];
      end
    end
    for (int i = 0; i < BEHIND_DEPTH; i++) begin
      back_vec[8*i +: 8] = behind[i];
    end
  end

  assign take_in = win[0];
  assign avail   = (phase == PH_RUN) ? CNT_W'(AHEAD_DEPTH) : count - 1'b1;
  assign do_take = (in_xfer && !s_axis_tlast && count == CNT_W'(AHEAD_DEPTH)) ||
                   (phase == PH_DRAIN && advance);
  assign tk = take_byte(take_in, fwd_vec, avail, flags, back_vec, behind_count);

  always_comb begin
    phase_next        = phase;
    count_next        = count;
    behind_count_next = behind_count;
    flags_next        = flags;
    held_valid_next   = held_valid;
    held_byte_next    = held_byte;
    o_valid_next      = o_valid && !m_axis_tready;
    o_byte_next       = o_byte;
    o_flag_next       = o_flag;
    o_last_next       = o_last;
    for (int i = 0; i < WIN_DEPTH; i++) win_next[i] = win[i];
    for (int i = 0; i < BEHIND_DEPTH; i++) behind_next[i] = behind[i];

    if (do_take) begin
      flags_next     = tk.flags;
      behind_next[0] = take_in;
      for (int i = 1; i < BEHIND_DEPTH; i++) behind_next[i] = behind[i-1];
      if (behind_count != '1) behind_count_next = behind_count + 1'b1;
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_next[i] = win[i+1];
    end

    case (phase)
      PH_RUN: begin
        if (in_xfer) begin
          if (!s_axis_tlast && count == CNT_W'(AHEAD_DEPTH)) begin
            win_next[AHEAD_DEPTH-1] = s_axis_tdata;
            if (tk.emit) begin
              o_valid_next = 1'b1;
              o_byte_next  = tk.data;
              o_flag_next  = 1'b1;
              o_last_next  = 1'b0;
            end
          end else begin
            win_next[count] = s_axis_tdata;
            count_next      = count + 1'b1;
            if (s_axis_tlast) phase_next = PH_DRAIN;
          end
        end
      end
      PH_DRAIN: begin
        if (advance) begin
          count_next = count - 1'b1;
          // one result is held back so the final one can carry tlast
          if (tk.emit) begin
            held_valid_next = 1'b1;
            held_byte_next  = tk.data;
            if (held_valid) begin
              o_valid_next = 1'b1;
              o_byte_next  = held_byte;
              o_flag_next  = 1'b1;
              o_last_next  = 1'b0;
            end
          end
          if (count == CNT_W'(1)) phase_next = PH_FINISH;
        end
      end
      PH_FINISH: begin
        if (advance) begin
          o_valid_next      = 1'b1;
          o_byte_next       = held_valid ? held_byte : 8'd0;
          o_flag_next       = held_valid;
          o_last_next       = 1'b1;
          held_valid_next   = 1'b0;
          count_next        = '0;
          behind_count_next = '0;
          flags_next        = FLAGS_RESET;
          phase_next        = PH_RUN;
        end
      end
      default: begin
        phase_next = PH_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RUN;
      count        <= '0;
      behind_count <= '0;
      flags        <= FLAGS_RESET;
      held_valid   <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      phase        <= phase_next;
      count        <= count_next;
      behind_count <= behind_count_next;
      flags        <= flags_next;
      held_valid   <= held_valid_next;
      o_valid      <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) win[i] <= win_next[i];
    for (int i = 0; i < BEHIND_DEPTH; i++) behind[i] <= behind_next[i];
    held_byte <= held_byte_next;
    o_byte    <= o_byte_next;
    o_flag    <= o_flag_next;
    o_last    <= o_last_next;
  end

endmodule

@@ verif/html_text_extract_filter_tb.sv @@
module html_text_extract_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hte_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RAND_BYTES   = 400;
  localparam int SQUEEZE_CYC  = 60;
  localparam int TAIL_CYC     = 20;

  typedef struct packed {
    logic [7:0] b;
    logic       v;
    logic       l;
  } text_res_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    bit         typed;
    logic [7:0] eb;
    logic       ev;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  // text filter model state
  logic [7:0]  look_q[$];
  logic [7:0]  recent_b [BEHIND_DEPTH];
  int          recent_n;
  flags_t      fl;
  text_res_t   fresh_q[$];
  text_res_t   text_q[$];

  plan_row_t   plan[$];
  int          errs = 0;
  int          idle_cyc = 0;
  int          bytes_in = 0;
  int          pages_in = 0;
  int          results_out = 0;
  bit          quiet = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;
  text_res_t   got;

  always #2 clk = ~clk;

  html_text_extract_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  task automatic filter_reset();
    look_q.delete();
    foreach (recent_b[i]) recent_b[i] = 8'h00;
    recent_n = 0;
    fl = FLAGS_RESET;
  endtask

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit seq_ahead(input logic [7:0] w[$], input int pos, input string s);
    if (w.size() - 1 - pos < s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (w[pos + 1 + i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  // close marker must sit right before the '>' with at least one more byte before it in the page
  function automatic bit seq_behind(input string s);
    int n;
    n = s.len();
    if (n > BEHIND_DEPTH || recent_n <= n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (recent_b[n - 1 - i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic emit_text(input logic [7:0] b);
    fresh_q.push_back('{b, 1'b1, 1'b0});
  endtask

  task automatic filter_take(input logic [7:0] w[$], input int pos);
    logic [7:0] b;
    int avail;
    b = w[pos];
    avail = w.size() - 1 - pos;
    if (fl.stopped) begin
      // rest of page dropped
    end else if (fl.entity_skip) begin
      if (b == CH_SEMI) fl.entity_skip = 1'b0;
    end else if (is_blank(b)) begin
      if (!fl.space_pending) begin
        emit_text(CH_SPACE);
        fl.space_pending = 1'b1;
      end
    end else if (b == CH_LT) begin
      if (!fl.deleting) begin
        fl.in_tag_open = 1'b1;
        fl.tag_closed = 1'b0;
        if (seq_ahead(w, pos, "script")) fl.deleting = 1'b1;
        else if (avail < 7) fl.stopped = 1'b1;
        else if (seq_ahead(w, pos, "noscript") || seq_ahead(w, pos, "style") ||
                 seq_ahead(w, pos, "code") || w[pos + 1] == CH_HASH)
          fl.deleting = 1'b1;
        else fl.deleting = 1'b0;
      end
    end else if (b == CH_GT) begin
      if (fl.deleting && (seq_behind("/script") || seq_behind("/noscript") ||
          seq_behind("/style") || seq_behind("/code") || seq_behind("/#")))
        fl.deleting = 1'b0;
      if (fl.in_tag_open) begin
        fl.tag_closed = 1'b1;
        fl.in_tag_open = 1'b0;
      end
    end else if (b == CH_AMP) begin
      if (!fl.deleting && fl.tag_closed) fl.entity_skip = 1'b1;
    end else if (!fl.deleting && fl.tag_closed) begin
      emit_text(b);
      fl.space_pending = 1'b0;
    end
    for (int i = BEHIND_DEPTH - 1; i > 0; i--) recent_b[i] = recent_b[i - 1];
    recent_b[0] = b;
    if (recent_n < 15) recent_n++;
  endtask

  task automatic filter_step(input logic [7:0] b, input logic l);
    logic [7:0] w[$];
    w = look_q;
    w.push_back(b);
    fresh_q.delete();
    if (!l) begin
      if (w.size() == WIN_DEPTH) begin
        filter_take(w, 0);
        void'(w.pop_front());
      end
      look_q = w;
    end else begin
      for (int i = 0; i < w.size(); i++) filter_take(w, i);
      if (fresh_q.size() == 0) fresh_q.push_back('{8'h00, 1'b0, 1'b1});
      else fresh_q[fresh_q.size() - 1].l = 1'b1;
      filter_reset();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input logic [7:0] eb, input logic ev);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    filter_step(b, l);
    if (typed) begin
      fresh_q.delete();
      fresh_q.push_back('{eb, ev, 1'b1});
    end
    foreach (fresh_q[i]) text_q.push_back(fresh_q[i]);
    bytes_in++;
    if (l) pages_in++;
  endtask

  task automatic plan_text(input string s);
    for (int i = 0; i < s.len(); i++)
      plan.push_back('{s[i], i == s.len() - 1, 1'b0, 8'h00, 1'b0});
  endtask

  task automatic push_str(inout logic [7:0] pg[$], input string s);
    for (int i = 0; i < s.len(); i++) pg.push_back(s[i]);
  endtask

  // mostly markup-shaped pages with random content, some noise and cut-off pages
  task automatic make_page(output logic [7:0] pg[$]);
    string tags[] = '{"<script>", "</script>", "<noscript>", "</noscript>", "<style>",
                      "</style>", "<code>", "</code>", "<#", "/#>", "<p>", "</p>",
                      "<a href=x>", "<br/>", "<scrip>", "</b>", ">", "<"};
    string ents[] = '{"&amp;", "&lt;", "&x", ";", "&"};
    logic [7:0] ws[] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    int k;
    pg.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) pg.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(0, 19);
        if (k < 7) push_str(pg, tags[$urandom_range(0, tags.size() - 1)]);
        else if (k < 13)
          repeat ($urandom_range(1, 6)) pg.push_back(8'($urandom_range(8'h21, 8'h7e)));
        else if (k < 16) repeat ($urandom_range(1, 3)) pg.push_back(ws[$urandom_range(0, 5)]);
        else if (k < 18) push_str(pg, ents[$urandom_range(0, ents.size() - 1)]);
        else pg.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0 && pg.size() > 1)
        pg = pg[0:$urandom_range(0, pg.size() - 1)];
    end
  endtask

  task automatic note_mismatch(input string what, input text_res_t want,
                               input text_res_t seen);
    errs++;
    if (errs <= 10)
      $display("%0t %s: expected byte %02h valid %0b last %0b, %s %02h valid %0b last %0b",
               $realtime, what, want.b, want.v, want.l, "got byte", seen.b, seen.v, seen.l);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast};
      results_out++;
      if (text_q.size() == 0) note_mismatch("unexpected result", '0, got);
      else if (text_q[0] != got) note_mismatch("result mismatch", text_q.pop_front(), got);
      else void'(text_q.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random backpressure bursts plus one long hold to fill the pipe
  initial begin
    @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYC) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] pg[$];
    int rand_n;
    filter_reset();
    // single-byte pages: extremes, whitespace and the markup characters, then short multi-byte pages
    plan.push_back('{8'h41, 1'b1, 1'b1, 8'h41, 1'b1});
    plan.push_back('{8'h00, 1'b1, 1'b1, 8'h00, 1'b1});
    plan.push_back('{8'hff, 1'b1, 1'b1, 8'hff, 1'b1});
    plan.push_back('{CH_CR, 1'b1, 1'b1, CH_SPACE, 1'b1});
    plan.push_back('{CH_LT, 1'b1, 1'b1, 8'h00, 1'b0});
    plan.push_back('{CH_AMP, 1'b1, 1'b1, 8'h00, 1'b0});
    plan.push_back('{CH_GT, 1'b1, 1'b1, 8'h00, 1'b0});
    plan_text("<script");
    plan_text(" \t x");
    plan_text("a&b;c");

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_byte(plan[i].b, plan[i].l, plan[i].typed, plan[i].eb, plan[i].ev);

    rand_n = 0;
    while (rand_n < RAND_BYTES) begin
      make_page(pg);
      foreach (pg[i]) begin
        if (rand_n == RAND_BYTES / 3) squeeze_req = 1'b1;
        if (rand_n >= RAND_BYTES - 60) quiet = 1'b1;
        send_byte(pg[i], i == pg.size() - 1, 1'b0, 8'h00, 1'b0);
        rand_n++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    errs += text_q.size();

    $display("%0d pages (%0d bytes) pushed through the filter, %0d text results checked",
             pages_in, bytes_in, results_out);
    $display("random pages mixed markup, deleted regions, entities, whitespace and noise");
    if (errs == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ html_text_extract_filter.f @@
rtl/hte_pkg.sv
rtl/html_text_extract_filter.sv
verif/html_text_extract_filter_tb.sv
